>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define UTEL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UTEL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/utel_pkg.sv
// types, constants and calendar helpers for the utc to local time converter
`default_nettype none

package utel_pkg;

    // one calendar timestamp as it moves down the pipeline
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_stamp;

    // leap flag and weekday base with its mod-7 reciprocal product
    typedef struct packed {
        logic        leap;
        logic [12:0] base;
        logic [26:0] prod;
    } t_dow;

    // summer decision, leap flag and offset hour sum
    typedef struct packed {
        logic       summer;
        logic       leap;
        logic [5:0] hour_sum;
    } t_adj;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_WINTER   = 2'd0;
    localparam logic [1:0] CFG_SUMMER   = 2'd1;
    localparam logic [3:0] WINTER_RESET = 4'd1;
    localparam logic [3:0] SUMMER_RESET = 4'd2;

    // reciprocals for division by 25 and by 7
    localparam logic [10:0] RECIP_25 = 11'd1311;
    localparam int          SHIFT_25 = 15;
    localparam logic [13:0] RECIP_7  = 14'd9363;
    localparam int          SHIFT_7  = 16;

    // month codes
    localparam logic [3:0] M_NONE = 4'd0;
    localparam logic [3:0] M_JAN  = 4'd1;
    localparam logic [3:0] M_FEB  = 4'd2;
    localparam logic [3:0] M_MAR  = 4'd3;
    localparam logic [3:0] M_APR  = 4'd4;
    localparam logic [3:0] M_MAY  = 4'd5;
    localparam logic [3:0] M_JUN  = 4'd6;
    localparam logic [3:0] M_JUL  = 4'd7;
    localparam logic [3:0] M_AUG  = 4'd8;
    localparam logic [3:0] M_SEP  = 4'd9;
    localparam logic [3:0] M_OCT  = 4'd10;
    localparam logic [3:0] M_NOV  = 4'd11;
    localparam logic [3:0] M_DEC  = 4'd12;

    // march and october both have 31 days; weekday table entries 2 and 6
    localparam int          LAST_DAY  = 31;
    localparam logic [2:0]  MAR_SHIFT = 3'((LAST_DAY + 2) % 7);
    localparam logic [2:0]  OCT_SHIFT = 3'((LAST_DAY + 6) % 7);
    localparam logic [4:0]  LONG_LEN  = 5'(LAST_DAY);
    localparam logic [5:0]  DAY_HOURS = 6'd24;

    // month length; codes outside january to december count as 31 days
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            M_FEB:                      n = leap ? 5'd29 : 5'd28;
            M_APR, M_JUN, M_SEP, M_NOV: n = 5'd30;
            default:                    n = LONG_LEN;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utc_to_eu_local_time.sv
// top level of the utc to european local time converter
//
// Converts one UTC date and time into local civil time with European summer
// time, decided at the UTC day boundary from the last sundays of march and
// october. A request is taken at each rising edge with i_start high and
// o_busy low; o_busy is always low, so a new request may come every cycle.
// The result appears on the o_local_* ports and o_summer_time for exactly one
// cycle, marked by o_valid, once the request has passed all pipeline stages.
// Throughput is one request per cycle through a five
// stage pipeline: year/100 and year/400 products, leap test and weekday base,
// mod-7 product, summer decision with the hour add, and the day/month/year
// carry. Results come out in request order.
// The receiver cannot stall, so nothing is ever held back.
// Offsets are written through i_cfg_we / i_cfg_index / i_cfg_data: index 0 is
// the winter offset, index 1 the summer offset, other indexes are ignored.
// Write them only while no request is in flight.
// Synchronous reset clears the pipeline valid bits and sets the offsets to
// one hour in winter and two hours in summer.
`default_nettype none

module utc_to_eu_local_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [11:0] i_utc_year,
    input  logic [3:0]  i_utc_month,
    input  logic [4:0]  i_utc_day,
    input  logic [4:0]  i_utc_hour,
    input  logic [5:0]  i_utc_minute,
    input  logic [5:0]  i_utc_second,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    output logic [11:0] o_local_year,
    output logic [3:0]  o_local_month,
    output logic [4:0]  o_local_day,
    output logic [4:0]  o_local_hour,
    output logic [5:0]  o_local_minute,
    output logic [5:0]  o_local_second,
    output logic        o_summer_time
);
    import utel_pkg::*;

`include "assert_macros.svh"

    logic       r_winter_off;
    logic [3:0] r_winter_hours;
    logic [3:0] r_summer_hours;

    t_stamp     w_in_stamp;
    logic       w_dow_valid;
    t_stamp     w_dow_stamp;
    t_dow       w_dow;
    logic       w_adj_valid;
    t_stamp     w_adj_stamp;
    t_adj       w_adj;
    t_stamp     w_out_stamp;

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_winter_hours <= WINTER_RESET;
            r_summer_hours <= SUMMER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WINTER) begin
                r_winter_hours <= i_cfg_data;
            end
            if (i_cfg_index == CFG_SUMMER) begin
                r_summer_hours <= i_cfg_data;
            end
        end
    end

    // tracks whether the last offset write went to the winter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_winter_off <= 1'b0;
        end else if (i_cfg_we) begin
            r_winter_off <= (i_cfg_index == CFG_WINTER);
        end
    end

    // request fields
    assign w_in_stamp.year   = i_utc_year;
    assign w_in_stamp.month  = i_utc_month;
    assign w_in_stamp.day    = i_utc_day;
    assign w_in_stamp.hour   = i_utc_hour;
    assign w_in_stamp.minute = i_utc_minute;
    assign w_in_stamp.second = i_utc_second;

    assign o_busy = 1'b0;

    // pipeline
    utel_dow u_dow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_stamp (w_in_stamp),
        .o_valid (w_dow_valid),
        .o_stamp (w_dow_stamp),
        .o_dow   (w_dow)
    );

    utel_offset u_offset (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_dow_valid),
        .i_stamp      (w_dow_stamp),
        .i_dow        (w_dow),
        .i_winter_off (r_winter_hours),
        .i_summer_off (r_summer_hours),
        .o_valid      (w_adj_valid),
        .o_stamp      (w_adj_stamp),
        .o_adj        (w_adj)
    );

    utel_carry u_carry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_adj_valid),
        .i_stamp  (w_adj_stamp),
        .i_adj    (w_adj),
        .o_valid  (o_valid),
        .o_stamp  (w_out_stamp),
        .o_summer (o_summer_time)
    );

    // result fields
    assign o_local_year   = w_out_stamp.year;
    assign o_local_month  = w_out_stamp.month;
    assign o_local_day    = w_out_stamp.day;
    assign o_local_hour   = w_out_stamp.hour;
    assign o_local_minute = w_out_stamp.minute;
    assign o_local_second = w_out_stamp.second;

    // checks
    `UTEL_ASSERT_NXT(a_latency, i_start && !o_busy, ##4 o_valid, "result missing after request")
    `UTEL_ASSERT_IMP(a_no_spurious, o_valid, $past(i_start, 5), "result without request")
    `UTEL_ASSERT_IMP(a_hour_range, o_valid, o_local_hour < 5'd24, "local hour out of range")
    `UTEL_ASSERT_IMP(a_summer_month, o_valid && o_summer_time,
        o_local_month >= M_MAR && o_local_month <= M_OCT, "summer time outside march..october")
    `UTEL_ASSERT_IMP(a_cfg_track, $past(i_cfg_we) && r_winter_off,
        $past(i_cfg_data) == r_winter_hours, "winter offset write lost")

endmodule

`default_nettype wire

>>> hw/rtl/utel_dow.sv
// stages 1 to 3: leap year test and weekday base for the last-sunday rule
`default_nettype none

module utel_dow (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utel_pkg::t_stamp  i_stamp,
    output logic              o_valid,
    output utel_pkg::t_stamp  o_stamp,
    output utel_pkg::t_dow    o_dow
);
    import utel_pkg::*;

    logic        r_s1_valid;
    t_stamp      r_s1_stamp;
    logic [20:0] r_s1_p100;
    logic [18:0] r_s1_p400;

    logic        r_s2_valid;
    t_stamp      r_s2_stamp;
    logic        r_s2_leap;
    logic [12:0] r_s2_base;

    logic        r_s3_valid;
    t_stamp      r_s3_stamp;
    logic        r_s3_leap;
    logic [12:0] r_s3_base;
    logic [26:0] r_s3_prod;

    logic [5:0]  n_q100;
    logic [3:0]  n_q400;
    logic [11:0] n_m100;
    logic [7:0]  n_m25;
    logic        n_zero100;
    logic        n_zero400;
    logic        n_leap;
    logic [12:0] n_base;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage 1: year/4 and year/16 times the reciprocal of 25
    always_ff @(posedge i_clk) begin
        r_s1_stamp <= i_stamp;
        r_s1_p100  <= {11'd0, i_stamp.year[11:2]} * {10'd0, RECIP_25};
        r_s1_p400  <= {11'd0, i_stamp.year[11:4]} * {8'd0, RECIP_25};
    end

    // stage 2: quotients, leap test, weekday base
    always_comb begin
        n_q100    = r_s1_p100[20:SHIFT_25];
        n_q400    = r_s1_p400[18:SHIFT_25];
        n_m100    = 12'(n_q100) * 12'd100;
        n_m25     = 8'(n_q400) * 8'd25;
        n_zero100 = (r_s1_stamp.year == n_m100);
        n_zero400 = (r_s1_stamp.year[3:0] == 4'd0) && (r_s1_stamp.year[11:4] == n_m25);
        n_leap    = ((r_s1_stamp.year[1:0] == 2'd0) && !n_zero100) || n_zero400;
        n_base    = 13'(r_s1_stamp.year) + 13'(r_s1_stamp.year[11:2])
                  - 13'(n_q100) + 13'(n_q400);
    end

    always_ff @(posedge i_clk) begin
        r_s2_stamp <= r_s1_stamp;
        r_s2_leap  <= n_leap;
        r_s2_base  <= n_base;
    end

    // stage 3: base times the reciprocal of 7
    always_ff @(posedge i_clk) begin
        r_s3_stamp <= r_s2_stamp;
        r_s3_leap  <= r_s2_leap;
        r_s3_base  <= r_s2_base;
        r_s3_prod  <= {14'd0, r_s2_base} * {13'd0, RECIP_7};
    end

    assign o_valid     = r_s3_valid;
    assign o_stamp     = r_s3_stamp;
    assign o_dow.leap  = r_s3_leap;
    assign o_dow.base  = r_s3_base;
    assign o_dow.prod  = r_s3_prod;

endmodule

`default_nettype wire

>>> hw/rtl/utel_offset.sv
// stage 4: last sundays of march and october, summer decision, hour offset
`default_nettype none

module utel_offset (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utel_pkg::t_stamp  i_stamp,
    input  utel_pkg::t_dow    i_dow,
    input  logic [3:0]        i_winter_off,
    input  logic [3:0]        i_summer_off,
    output logic              o_valid,
    output utel_pkg::t_stamp  o_stamp,
    output utel_pkg::t_adj    o_adj
);
    import utel_pkg::*;

    logic        r_valid;
    t_stamp      r_stamp;
    t_adj        r_adj;

    logic [10:0] n_q7;
    logic [12:0] n_diff;
    logic [2:0]  n_rem;
    logic [3:0]  n_mar_sum;
    logic [3:0]  n_oct_sum;
    logic [2:0]  n_mar_wd;
    logic [2:0]  n_oct_wd;
    logic [4:0]  n_last_mar;
    logic [4:0]  n_last_oct;
    logic        n_summer;
    logic [3:0]  n_off;

    // weekday of the 31st, then the last sunday of each switch month
    always_comb begin
        n_q7       = i_dow.prod[26:SHIFT_7];
        n_diff     = i_dow.base - 13'(n_q7) * 13'd7;
        n_rem      = n_diff[2:0];
        n_mar_sum  = {1'b0, n_rem} + {1'b0, MAR_SHIFT};
        n_oct_sum  = {1'b0, n_rem} + {1'b0, OCT_SHIFT};
        n_mar_wd   = (n_mar_sum >= 4'd7) ? 3'(n_mar_sum - 4'd7) : n_mar_sum[2:0];
        n_oct_wd   = (n_oct_sum >= 4'd7) ? 3'(n_oct_sum - 4'd7) : n_oct_sum[2:0];
        n_last_mar = LONG_LEN - 5'(n_mar_wd);
        n_last_oct = LONG_LEN - 5'(n_oct_wd);
    end

    // summer time from the utc date
    always_comb begin
        priority if (i_stamp.month >= M_APR && i_stamp.month <= M_SEP) begin
            n_summer = 1'b1;
        end else if (i_stamp.month == M_MAR) begin
            n_summer = (i_stamp.day >= n_last_mar);
        end else if (i_stamp.month == M_OCT) begin
            n_summer = (i_stamp.day < n_last_oct);
        end else begin
            n_summer = 1'b0;
        end
        n_off = n_summer ? i_summer_off : i_winter_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp          <= i_stamp;
        r_adj.summer     <= n_summer;
        r_adj.leap       <= i_dow.leap;
        r_adj.hour_sum   <= 6'(i_stamp.hour) + 6'(n_off);
    end

    assign o_valid = r_valid;
    assign o_stamp = r_stamp;
    assign o_adj   = r_adj;

endmodule

`default_nettype wire

>>> hw/rtl/utel_carry.sv
// stage 5: hour wrap with carry into day, month and year; output register
`default_nettype none

module utel_carry (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  utel_pkg::t_stamp  i_stamp,
    input  utel_pkg::t_adj    i_adj,
    output logic              o_valid,
    output utel_pkg::t_stamp  o_stamp,
    output logic              o_summer
);
    import utel_pkg::*;

    logic       r_valid;
    t_stamp     r_stamp;
    logic       r_summer;

    logic       n_roll;
    logic [4:0] n_len;
    logic [5:0] n_day_inc;
    logic       n_over;
    t_stamp     n_stamp;

    // carry chain
    always_comb begin
        n_roll    = (i_adj.hour_sum >= DAY_HOURS);
        n_len     = month_days(i_stamp.month, i_adj.leap);
        n_day_inc = 6'(i_stamp.day) + 6'd1;
        n_over    = (n_day_inc > 6'(n_len));
        n_stamp   = i_stamp;
        n_stamp.hour = n_roll ? 5'(i_adj.hour_sum - DAY_HOURS) : 5'(i_adj.hour_sum);
        if (n_roll) begin
            if (n_over) begin
                n_stamp.day = 5'd1;
                priority if (i_stamp.month == M_NONE) begin
                    n_stamp.month = M_JAN;
                end else if (i_stamp.month >= M_DEC) begin
                    n_stamp.month = M_JAN;
                    n_stamp.year  = i_stamp.year + 12'd1;
                end else begin
                    n_stamp.month = i_stamp.month + 4'd1;
                end
            end else begin
                n_stamp.day = n_day_inc[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp  <= n_stamp;
        r_summer <= i_adj.summer;
    end

    assign o_valid  = r_valid;
    assign o_stamp  = r_stamp;
    assign o_summer = r_summer;

endmodule

`default_nettype wire
